// ===== design/circulant_global_link_map_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Circulant global link map: assertion macros
// Shared concurrent assertion helpers, clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef CIRCULANT_GLOBAL_LINK_MAP_UNIT_MACROS_SVH
`define CIRCULANT_GLOBAL_LINK_MAP_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CGLM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cglm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CGLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cglm assertion failed");

`else

`define CGLM_ASSERT_IMP(lbl, ante, cons)
`define CGLM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/cglm_pkg.sv =====
// ----------------------------------------------------------------------------
// Circulant global link map: shared package
// Types, constants and helper functions used by all modules of the block.
// ----------------------------------------------------------------------------
package cglm_pkg;

    // Limits of the effective configuration.
    localparam int MAX_ROUTERS    = 32;
    localparam int MAX_GROUPS     = 256;
    localparam int MAX_HALF_LINKS = 16;

    // Register and field widths.
    localparam int SIZE_W     = 6;
    localparam int GROUPS_W   = 9;
    localparam int HALF_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int GRP_W      = 8;
    localparam int ROUTER_W   = 5;
    localparam int PORT_W     = 5;
    localparam int SWITCH_W   = 13;
    localparam int COUNT_W    = 6;

    // Remainder unit: dividend width and iteration counter width.
    localparam int DIV_W     = 9;
    localparam int DIV_CNT_W = 4;

    // Job queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Reset values of the configuration registers.
    localparam logic [SIZE_W-1:0]   RST_ROUTERS     = SIZE_W'(4);
    localparam logic [GROUPS_W-1:0] RST_GROUP_COUNT = GROUPS_W'(9);
    localparam logic [HALF_W-1:0]   RST_HALF_LINKS  = HALF_W'(1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROUTERS     = 2'd0,
        REG_GROUP_COUNT = 2'd1,
        REG_HALF_LINKS  = 2'd2
    } cfg_reg_t;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_NEIGHBOURS = 2'd0;
    localparam logic [1:0] OP_GROUP      = 2'd1;
    localparam logic [1:0] OP_PORT       = 2'd2;

    // Job class assigned by the front part.
    typedef enum logic [1:0] {
        JOB_NEIGH,
        JOB_GROUP,
        JOB_PORT,
        JOB_EMPTY
    } job_kind_t;

    // Back part sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_SG,
        ST_MOD_BASE,
        ST_WALK_N,
        ST_WALK_G,
        ST_FLUSH
    } back_state_t;

    // Input beat.
    typedef struct packed {
        logic [1:0]          operation;
        logic [ROUTER_W-1:0] src_router;
        logic [GRP_W-1:0]    src_group;
        logic [GRP_W-1:0]    dst_group;
        logic [PORT_W-1:0]   src_port;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic [SWITCH_W-1:0] neighbour_switch;
        logic [ROUTER_W-1:0] router_index;
        logic [PORT_W-1:0]   port_index;
        logic                found;
        logic                last;
    } out_item_t;

    // Effective configuration after clamping.
    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [GROUPS_W-1:0] groups;
        logic [HALF_W-1:0]   half;
    } cfg_t;

    // Classified job handed from the front to the back part.
    typedef struct packed {
        job_kind_t           kind;
        logic [ROUTER_W-1:0] src_router;
        logic [GRP_W-1:0]    src_group;
        logic [GRP_W-1:0]    dst_group;
        logic [PORT_W-1:0]   src_port;
        logic [DIV_W-1:0]    prod;
    } job_t;

    // Request to the remainder unit.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } mod_req_t;

    // Status of the remainder unit.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [GRP_W-1:0] rem;
    } mod_rsp_t;

    // Clamp the raw registers into their usable ranges.
    function automatic cfg_t eff_cfg(input logic [SIZE_W-1:0]   router_count,
                                     input logic [GROUPS_W-1:0] group_count,
                                     input logic [HALF_W-1:0]   half_links);
        cfg_t c;
        if (router_count == '0)
            c.size = SIZE_W'(1);
        else if (router_count > SIZE_W'(MAX_ROUTERS))
            c.size = SIZE_W'(MAX_ROUTERS);
        else
            c.size = router_count;
        if (group_count == '0)
            c.groups = GROUPS_W'(1);
        else if (group_count > GROUPS_W'(MAX_GROUPS))
            c.groups = GROUPS_W'(MAX_GROUPS);
        else
            c.groups = group_count;
        if (half_links > HALF_W'(MAX_HALF_LINKS))
            c.half = HALF_W'(MAX_HALF_LINKS);
        else
            c.half = half_links;
        return c;
    endfunction

endpackage

// ===== design/cglm_mod.sv =====
// ----------------------------------------------------------------------------
// Circulant global link map: remainder unit
// Restoring shift-subtract remainder of a small dividend by the group count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module cglm_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cglm_pkg::GROUPS_W-1:0] divisor,
    input  cglm_pkg::mod_req_t          req,
    output cglm_pkg::mod_rsp_t          rsp
);
    import cglm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [GRP_W-1:0]     rem_reg, rem_next;
    logic [GROUPS_W-1:0]  trial;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    assign trial = {rem_reg, dvd_reg[DIV_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (trial >= divisor)
                rem_next = GRP_W'(trial - divisor);
            else
                rem_next = trial[GRP_W-1:0];
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== design/cglm_queue.sv =====
// ----------------------------------------------------------------------------
// Circulant global link map: job queue
// Short FIFO that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module cglm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cglm_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output cglm_pkg::job_t q_data
);
    import cglm_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== design/cglm_front.sv =====
// ----------------------------------------------------------------------------
// Circulant global link map: front part
// Accepts input beats, classifies the operation and prepares the first
// operand of the neighbour walk before the job enters the queue.
// ----------------------------------------------------------------------------
module cglm_front (
    input  logic               req_valid,
    output logic               req_stall,
    input  cglm_pkg::in_item_t req_data,
    input  cglm_pkg::cfg_t     cfg,
    input  logic               q_full,
    output logic               q_push,
    output cglm_pkg::job_t     q_wdata
);
    import cglm_pkg::*;

    logic [2*HALF_W-1:0] prod_wide;

    // The queue accepts a beat whenever it has room.
    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    // Router times half links: the circulant offset before reduction.
    assign prod_wide = (2*HALF_W)'(req_data.src_router) * (2*HALF_W)'(cfg.half);

    always_comb
    begin
        q_wdata.src_router = req_data.src_router;
        q_wdata.src_group  = req_data.src_group;
        q_wdata.dst_group  = req_data.dst_group;
        q_wdata.src_port   = req_data.src_port;
        q_wdata.prod       = prod_wide[DIV_W-1:0];
        case (req_data.operation)
            OP_NEIGHBOURS: q_wdata.kind = JOB_NEIGH;
            OP_GROUP:      q_wdata.kind = JOB_GROUP;
            OP_PORT:       q_wdata.kind = JOB_PORT;
            default:       q_wdata.kind = JOB_EMPTY;
        endcase
    end

endmodule

// ===== design/cglm_back.sv =====
// ----------------------------------------------------------------------------
// Circulant global link map: back part
// Sequencer that reduces the group offsets, walks the link lists and
// delivers result beats through a holding slot and an output register.
// ----------------------------------------------------------------------------
`include "circulant_global_link_map_unit_macros.svh"

module cglm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cglm_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  cglm_pkg::job_t      q_data,
    output logic                q_pop,
    output cglm_pkg::mod_req_t  mod_req,
    input  cglm_pkg::mod_rsp_t  mod_rsp,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cglm_pkg::out_item_t rsp_data
);
    import cglm_pkg::*;

    back_state_t         state_reg, state_next;
    job_t                job_reg, job_next;
    logic [GRP_W-1:0]    sgm_reg, sgm_next;
    logic [GRP_W-1:0]    hm_reg, hm_next;
    logic [GRP_W-1:0]    base_reg, base_next;
    logic [GRP_W-1:0]    off_reg, off_next;
    logic [HALF_W-1:0]   k_reg, k_next;
    logic                sub_reg, sub_next;
    logic [ROUTER_W-1:0] r_reg, r_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    out_item_t           pend_reg, pend_next;
    logic                rsp_valid_reg;
    out_item_t           rsp_data_reg;

    logic                push;
    out_item_t           push_data;
    logic                push_ok;
    logic [GROUPS_W-1:0] off_p1;
    logic [GRP_W-1:0]    cur_off;
    logic [GROUPS_W-1:0] plus_sum;
    logic [GRP_W-1:0]    plus_grp;
    logic [GROUPS_W-1:0] minus_wide;
    logic [GRP_W-1:0]    minus_grp;
    logic                plus_keep;
    logic                minus_keep;
    logic                k_last;
    logic [GRP_W-1:0]    n_grp;
    logic                n_keep;
    logic [SWITCH_W:0]   sw_wide;
    logic                p_hit;
    logic                m_hit;
    logic                g_hit;
    logic [PORT_W-1:0]   hit_port;
    logic [COUNT_W-1:0]  cnt_sum;
    logic [GROUPS_W-1:0] base_sum;
    logic [GRP_W-1:0]    base_nx;
    logic                last_router;
    logic                router_end;

    // The output register can take a beat when empty or being drained.
    assign push_ok = !rsp_valid_reg || !rsp_stall;

    // Offset of the current link: previous offset plus one, wrapped.
    assign off_p1  = {1'b0, off_reg} + GROUPS_W'(1);
    assign cur_off = (off_p1 == cfg.groups) ? '0 : off_p1[GRP_W-1:0];

    // Groups reached in the plus and minus direction.
    assign plus_sum   = {1'b0, sgm_reg} + {1'b0, cur_off};
    assign plus_grp   = (plus_sum >= cfg.groups) ? GRP_W'(plus_sum - cfg.groups)
                                                 : plus_sum[GRP_W-1:0];
    assign minus_wide = {1'b0, sgm_reg} + cfg.groups - {1'b0, cur_off};
    assign minus_grp  = (sgm_reg >= cur_off) ? sgm_reg - cur_off
                                             : minus_wide[GRP_W-1:0];

    // A link that lands back in the source group is dropped.
    assign plus_keep  = plus_grp != job_reg.src_group;
    assign minus_keep = minus_grp != job_reg.src_group;
    assign k_last     = k_reg == cfg.half;

    // Neighbour walk: one list entry per cycle while the output register has room.
    assign n_grp   = sub_reg ? minus_grp : plus_grp;
    assign n_keep  = sub_reg ? minus_keep : plus_keep;
    assign sw_wide = (SWITCH_W+1)'(n_grp) * (SWITCH_W+1)'(cfg.size)
                   + (SWITCH_W+1)'(job_reg.src_router);

    // Group walk: both entries of one link pair per cycle while the output register has room.
    assign p_hit    = plus_keep && (plus_grp == job_reg.dst_group);
    assign m_hit    = minus_keep && (minus_grp == job_reg.dst_group);
    assign g_hit    = p_hit || m_hit;
    assign hit_port = p_hit ? cnt_reg[PORT_W-1:0]
                            : PORT_W'(cnt_reg + COUNT_W'(plus_keep));
    assign cnt_sum  = cnt_reg + COUNT_W'(plus_keep) + COUNT_W'(minus_keep);

    // Base offset of the next router: add half links modulo the group count.
    assign base_sum    = {1'b0, base_reg} + {1'b0, hm_reg};
    assign base_nx     = (base_sum >= cfg.groups) ? GRP_W'(base_sum - cfg.groups)
                                                  : base_sum[GRP_W-1:0];
    assign last_router = {1'b0, r_reg} == (cfg.size - SIZE_W'(1));
    assign router_end  = g_hit || k_last;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_data.kind) inside
                        JOB_NEIGH, JOB_GROUP: state_next = ST_MOD_SG;
                        default:              state_next = ST_FLUSH;
                    endcase
                end
            end
            ST_MOD_SG:
            begin
                if (mod_rsp.done)
                    state_next = ST_MOD_BASE;
            end
            ST_MOD_BASE:
            begin
                if (mod_rsp.done)
                begin
                    if (cfg.half == '0)
                        state_next = ST_FLUSH;
                    else if (job_reg.kind == JOB_NEIGH)
                        state_next = ST_WALK_N;
                    else
                        state_next = ST_WALK_G;
                end
            end
            ST_WALK_N:
            begin
                if (push_ok && sub_reg && k_last)
                    state_next = ST_FLUSH;
            end
            ST_WALK_G:
            begin
                if (push_ok && router_end && last_router)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (push_ok)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        q_pop            = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = '0;
        push             = 1'b0;
        push_data        = pend_reg;
        job_next         = job_reg;
        sgm_next         = sgm_reg;
        hm_next          = hm_reg;
        base_next        = base_reg;
        off_next         = off_reg;
        k_next           = k_reg;
        sub_next         = sub_reg;
        r_next           = r_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    job_next = q_data;
                    case (q_data.kind)
                        JOB_NEIGH, JOB_GROUP:
                        begin
                            mod_req.start    = 1'b1;
                            mod_req.dividend = DIV_W'(q_data.src_group);
                        end
                        JOB_PORT:
                        begin
                            pend_valid_next      = 1'b1;
                            pend_next            = '0;
                            pend_next.port_index = q_data.src_port ^ PORT_W'(1);
                            pend_next.found      = 1'b1;
                        end
                        default: pend_valid_next = 1'b0;
                    endcase
                end
            end
            ST_MOD_SG:
            begin
                // Source group reduced; now reduce the walk's base step.
                if (mod_rsp.done)
                begin
                    sgm_next      = mod_rsp.rem;
                    mod_req.start = 1'b1;
                    if (job_reg.kind == JOB_NEIGH)
                        mod_req.dividend = job_reg.prod;
                    else
                        mod_req.dividend = DIV_W'(cfg.half);
                end
            end
            ST_MOD_BASE:
            begin
                if (mod_rsp.done)
                begin
                    hm_next   = mod_rsp.rem;
                    base_next = '0;
                    off_next  = (job_reg.kind == JOB_NEIGH) ? mod_rsp.rem : '0;
                    k_next    = HALF_W'(1);
                    sub_next  = 1'b0;
                    r_next    = '0;
                    cnt_next  = '0;
                end
            end
            ST_WALK_N:
            begin
                if (push_ok)
                begin
                    if (n_keep)
                    begin
                        push                       = pend_valid_reg;
                        pend_valid_next            = 1'b1;
                        pend_next                  = '0;
                        pend_next.neighbour_switch = sw_wide[SWITCH_W-1:0];
                        pend_next.found            = 1'b1;
                    end
                    sub_next = !sub_reg;
                    if (sub_reg)
                    begin
                        off_next = cur_off;
                        k_next   = k_reg + HALF_W'(1);
                    end
                end
            end
            ST_WALK_G:
            begin
                if (push_ok)
                begin
                    if (g_hit)
                    begin
                        push                   = pend_valid_reg;
                        pend_valid_next        = 1'b1;
                        pend_next              = '0;
                        pend_next.router_index = r_reg;
                        pend_next.port_index   = hit_port;
                        pend_next.found        = 1'b1;
                    end
                    if (router_end)
                    begin
                        r_next    = r_reg + ROUTER_W'(1);
                        base_next = base_nx;
                        off_next  = base_nx;
                        k_next    = HALF_W'(1);
                        cnt_next  = '0;
                    end
                    else
                    begin
                        k_next   = k_reg + HALF_W'(1);
                        off_next = cur_off;
                        cnt_next = cnt_sum;
                    end
                end
            end
            ST_FLUSH:
            begin
                // The held entry, or an empty marker, closes the item.
                if (push_ok)
                begin
                    push = 1'b1;
                    if (!pend_valid_reg)
                        push_data = '0;
                    push_data.last  = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: q_pop = 1'b0;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= push || (rsp_valid_reg && rsp_stall);
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        sgm_reg  <= sgm_next;
        hm_reg   <= hm_next;
        base_reg <= base_next;
        off_reg  <= off_next;
        k_reg    <= k_next;
        sub_reg  <= sub_next;
        r_reg    <= r_next;
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
        if (push)
            rsp_data_reg <= push_data;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // A result beat is only produced when the output register has room.
    `CGLM_ASSERT_IMP(a_push_room, push, push_ok)
    // The holding slot only ever carries real entries.
    `CGLM_ASSERT_IMP(a_pend_found, pend_valid_reg, pend_reg.found)
    // During a walk the offsets stay reduced below the group count.
    `CGLM_ASSERT_IMP(a_walk_reduced, (state_reg == ST_WALK_N || state_reg == ST_WALK_G), (GROUPS_W'(off_reg) < cfg.groups && GROUPS_W'(sgm_reg) < cfg.groups))
    // The remainder unit only reports while the sequencer waits for it.
    `CGLM_ASSERT_IMP(a_mod_owner, mod_rsp.done, (state_reg == ST_MOD_SG || state_reg == ST_MOD_BASE))

endmodule

// ===== design/circulant_global_link_map_unit.sv =====
// A peer port or empty query goes from the queue through the flush state to the output register;
// neighbour and group queries first take two 9-step remainder passes.
// Neighbour lists then give one entry per cycle while the output is not stalled;
// group queries check one link pair per cycle when not stalled, up to routers*half_links pairs.
// The back-part sequencer handles one item at a time; a 2-entry queue buffers input.
// Reset: configuration returns to 4 routers, 9 groups, 1 half link; the queue empties.
// ----------------------------------------------------------------------------
// Circulant global link map unit
// Maps global links of a dragonfly with circulant group wiring: neighbour
// switches, routers that reach a group, and peer ports.
// ----------------------------------------------------------------------------
module circulant_global_link_map_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  cglm_pkg::in_item_t                  req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output cglm_pkg::out_item_t                 rsp_data,
    input  logic                                cfg_we,
    input  logic [cglm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cglm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cglm_pkg::*;

    logic [SIZE_W-1:0]   routers_reg, routers_next;
    logic [GROUPS_W-1:0] group_count_reg, group_count_next;
    logic [HALF_W-1:0]   half_links_reg, half_links_next;
    cfg_t                cfg;
    logic                q_full;
    logic                q_push;
    job_t                q_wdata;
    logic                q_valid;
    logic                q_pop;
    job_t                q_data;
    mod_req_t            mod_req;
    mod_rsp_t            mod_rsp;

    // Configuration register writes.
    always_comb
    begin
        routers_next     = routers_reg;
        group_count_next = group_count_reg;
        half_links_next  = half_links_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROUTERS:     routers_next     = cfg_data[SIZE_W-1:0];
                REG_GROUP_COUNT: group_count_next = cfg_data[GROUPS_W-1:0];
                REG_HALF_LINKS:  half_links_next  = cfg_data[HALF_W-1:0];
                default:         routers_next     = routers_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            routers_reg     <= RST_ROUTERS;
            group_count_reg <= RST_GROUP_COUNT;
            half_links_reg  <= RST_HALF_LINKS;
        end
        else
        begin
            routers_reg     <= routers_next;
            group_count_reg <= group_count_next;
            half_links_reg  <= half_links_next;
        end
    end

    // Clamped configuration seen by the datapath.
    assign cfg = eff_cfg(routers_reg, group_count_reg, half_links_reg);

    cglm_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cfg       (cfg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    cglm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    cglm_mod u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .divisor (cfg.groups),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    cglm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .mod_req   (mod_req),
        .mod_rsp   (mod_rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
